/* rtl/core/vtir_pkg.sv */
// ----------------------------------------------------------------------------
// vtir_pkg
// Shared types and constants of the interface adapter timer and interrupt
// register file.
// ----------------------------------------------------------------------------
package vtir_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_EVENT = 2'd3;

    // Register offsets
    localparam logic [3:0] REG_ORB    = 4'd0;
    localparam logic [3:0] REG_ORA    = 4'd1;
    localparam logic [3:0] REG_DDRB   = 4'd2;
    localparam logic [3:0] REG_DDRA   = 4'd3;
    localparam logic [3:0] REG_T1CL   = 4'd4;
    localparam logic [3:0] REG_T1CH   = 4'd5;
    localparam logic [3:0] REG_T1LL   = 4'd6;
    localparam logic [3:0] REG_T1LH   = 4'd7;
    localparam logic [3:0] REG_T2CL   = 4'd8;
    localparam logic [3:0] REG_T2CH   = 4'd9;
    localparam logic [3:0] REG_SR     = 4'd10;
    localparam logic [3:0] REG_ACR    = 4'd11;
    localparam logic [3:0] REG_PCR    = 4'd12;
    localparam logic [3:0] REG_IFR    = 4'd13;
    localparam logic [3:0] REG_IER    = 4'd14;
    localparam logic [3:0] REG_ORA_NH = 4'd15;

    // Interrupt flag bit positions
    localparam int FLAG_BITS = 7;
    localparam int FB_SR     = 2;
    localparam int FB_T2     = 5;
    localparam int FB_T1     = 6;
    localparam logic [2:0] EVENT_LAST = 3'd4;

    localparam int ACR_FREE_RUN_BIT = 6;
    localparam logic [15:0] FIRE_COUNT = 16'hFFFD;
    localparam logic [7:0]  ACR_MASK_RESET = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] reg_index;
        logic [7:0] write_data;
        logic [2:0] event_flag;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
    } t_result;

endpackage

/* rtl/core/vtir_in_stage.sv */
// ----------------------------------------------------------------------------
// vtir_in_stage
// Input register: holds one accepted transaction until the register file
// processes it.
// ----------------------------------------------------------------------------
module vtir_in_stage import vtir_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/core/vtir_regs.sv */
// ----------------------------------------------------------------------------
// vtir_regs
// Register file state: ports, direction registers, ACR, PCR, shift register,
// timer latches and counters, interrupt flags and enables. Works out the
// result of one transaction and updates the state in the same cycle.
// ----------------------------------------------------------------------------
module vtir_regs import vtir_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_advance,
    input  t_item      i_item,
    output t_result    o_result
);

    logic [7:0]           r_acr_mask, r_pa, r_pb, r_dir_a, r_dir_b, r_acr, r_pcr, r_sr;
    logic [7:0]           n_pa, n_pb, n_dir_a, n_dir_b, n_acr, n_pcr, n_sr;
    logic [15:0]          r_t1_latch, r_t1_count, r_t2_count;
    logic [15:0]          n_t1_latch, n_t1_count, n_t2_count;
    logic [7:0]           r_t2_latch_low, n_t2_latch_low;
    logic                 r_t1_armed, r_t2_armed, r_t1_pz, r_t2_pz;
    logic                 n_t1_armed, n_t2_armed, n_t1_pz, n_t2_pz;
    logic [FLAG_BITS-1:0] r_flags, r_enables, n_flags, n_enables;
    logic [15:0]          t1_dec, t2_dec;
    logic                 t1_pz_tick, t2_pz_tick;
    logic [7:0]           rd;

    assign t1_dec     = r_t1_count - 16'd1;
    assign t2_dec     = r_t2_count - 16'd1;
    assign t1_pz_tick = r_t1_pz || (r_t1_count == 16'd0);
    assign t2_pz_tick = r_t2_pz || (r_t2_count == 16'd0);

    always_comb begin
        n_pa = r_pa;  n_pb = r_pb;  n_dir_a = r_dir_a;  n_dir_b = r_dir_b;
        n_acr = r_acr;  n_pcr = r_pcr;  n_sr = r_sr;
        n_t1_latch = r_t1_latch;  n_t1_count = r_t1_count;  n_t2_count = r_t2_count;
        n_t2_latch_low = r_t2_latch_low;
        n_t1_armed = r_t1_armed;  n_t2_armed = r_t2_armed;
        n_t1_pz = r_t1_pz;  n_t2_pz = r_t2_pz;
        n_flags = r_flags;  n_enables = r_enables;
        rd = 8'd0;

        case (i_item.opcode)
            OP_READ: begin
                case (i_item.reg_index)
                    REG_ORB:            rd = r_pb;
                    REG_ORA, REG_ORA_NH: rd = r_pa;
                    REG_DDRB:           rd = r_dir_b;
                    REG_DDRA:           rd = r_dir_a;
                    REG_T1CL: begin
                        rd = r_t1_count[7:0];
                        n_flags[FB_T1] = 1'b0;
                    end
                    REG_T1CH:           rd = r_t1_count[15:8];
                    REG_T1LL:           rd = r_t1_latch[7:0];
                    REG_T1LH:           rd = r_t1_latch[15:8];
                    REG_T2CL: begin
                        rd = r_t2_count[7:0];
                        n_flags[FB_T2] = 1'b0;
                    end
                    REG_T2CH:           rd = r_t2_count[15:8];
                    REG_SR: begin
                        rd = r_sr;
                        n_flags[FB_SR] = 1'b0;
                    end
                    REG_ACR:            rd = r_acr;
                    REG_PCR:            rd = r_pcr;
                    REG_IFR:            rd = {|(r_flags & r_enables), r_flags};
                    default:            rd = {1'b1, r_enables};
                endcase
            end
            OP_WRITE: begin
                case (i_item.reg_index)
                    REG_ORB: n_pb = (r_pb & ~r_dir_b) | (i_item.write_data & r_dir_b);
                    REG_ORA, REG_ORA_NH: n_pa = i_item.write_data;
                    REG_DDRB: n_dir_b = i_item.write_data;
                    REG_DDRA: n_dir_a = i_item.write_data;
                    REG_T1CL, REG_T1LL: n_t1_latch[7:0] = i_item.write_data;
                    REG_T1CH: begin
                        n_flags[FB_T1] = 1'b0;
                        n_t1_latch[15:8] = i_item.write_data;
                        n_t1_count = {i_item.write_data, r_t1_latch[7:0]};
                        n_t1_armed = 1'b1;
                        n_t1_pz = 1'b0;
                    end
                    REG_T1LH: begin
                        n_t1_latch[15:8] = i_item.write_data;
                        n_flags[FB_T1] = 1'b0;
                    end
                    REG_T2CL: n_t2_latch_low = i_item.write_data;
                    REG_T2CH: begin
                        n_flags[FB_T2] = 1'b0;
                        n_t2_count = {i_item.write_data, r_t2_latch_low};
                        n_t2_armed = 1'b1;
                        n_t2_pz = 1'b0;
                    end
                    REG_SR: begin
                        n_sr = i_item.write_data;
                        n_flags[FB_SR] = 1'b0;
                    end
                    REG_ACR: n_acr = i_item.write_data & r_acr_mask;
                    REG_PCR: n_pcr = i_item.write_data;
                    REG_IFR: n_flags = r_flags & ~i_item.write_data[FLAG_BITS-1:0];
                    default: begin
                        // Bit 7 selects whether the one bits set or clear enables.
                        if (i_item.write_data[7]) begin
                            n_enables = r_enables | i_item.write_data[FLAG_BITS-1:0];
                        end else begin
                            n_enables = r_enables & ~i_item.write_data[FLAG_BITS-1:0];
                        end
                    end
                endcase
            end
            OP_TICK: begin
                // Both counters run on every tick; an armed timer fires on the tick that
                // would take its counter to FIRE_COUNT after the counter has passed zero.
                n_t1_count = t1_dec;
                n_t1_pz    = t1_pz_tick;
                n_t2_count = t2_dec;
                n_t2_pz    = t2_pz_tick;
                if (r_t1_armed && t1_pz_tick && (t1_dec == FIRE_COUNT)) begin
                    n_t1_count = r_t1_latch;
                    n_t1_pz    = 1'b0;
                    n_t1_armed = r_acr[ACR_FREE_RUN_BIT];
                    n_flags[FB_T1] = 1'b1;
                end
                if (r_t2_armed && t2_pz_tick && (t2_dec == FIRE_COUNT)) begin
                    n_t2_armed = 1'b0;
                    n_flags[FB_T2] = 1'b1;
                end
            end
            default: begin
                if (i_item.event_flag <= EVENT_LAST) begin
                    n_flags[i_item.event_flag] = 1'b1;
                end
            end
        endcase
    end

    assign o_result.read_data = rd;
    assign o_result.irq_line  = |(n_flags & n_enables);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acr_mask <= ACR_MASK_RESET;
        end else if (i_cfg_we) begin
            r_acr_mask <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa <= '0;  r_pb <= '0;  r_dir_a <= '0;  r_dir_b <= '0;
            r_acr <= '0;  r_pcr <= '0;  r_sr <= '0;
            r_t1_latch <= '1;  r_t1_count <= '1;  r_t2_count <= '1;
            r_t2_latch_low <= '0;
            r_t1_armed <= 1'b0;  r_t2_armed <= 1'b0;
            r_t1_pz <= 1'b0;  r_t2_pz <= 1'b0;
            r_flags <= '0;  r_enables <= '0;
        end else if (i_advance) begin
            r_pa <= n_pa;  r_pb <= n_pb;  r_dir_a <= n_dir_a;  r_dir_b <= n_dir_b;
            r_acr <= n_acr;  r_pcr <= n_pcr;  r_sr <= n_sr;
            r_t1_latch <= n_t1_latch;  r_t1_count <= n_t1_count;
            r_t2_count <= n_t2_count;  r_t2_latch_low <= n_t2_latch_low;
            r_t1_armed <= n_t1_armed;  r_t2_armed <= n_t2_armed;
            r_t1_pz <= n_t1_pz;  r_t2_pz <= n_t2_pz;
            r_flags <= n_flags;  r_enables <= n_enables;
        end
    end

endmodule

/* rtl/core/vtir_out_stage.sv */
// ----------------------------------------------------------------------------
// vtir_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module vtir_out_stage import vtir_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/core/via_timer_interrupt_registers.sv */
// ----------------------------------------------------------------------------
// via_timer_interrupt_registers
// Interface adapter register file with two timers and interrupt logic.
// ----------------------------------------------------------------------------
// Each transaction (register read, register write, timer tick or flag event)
// is taken into an input register and processed once the output register can
// take its result; the state is then updated and the result loaded into the
// output register. One transaction is accepted per cycle while the result
// side keeps up, a rate set by updating the register state at each advance.
// The user must write the ACR write mask through the configuration port only
// while no transaction is in flight; the block itself does not enforce this.
module via_timer_interrupt_registers import vtir_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [3:0] i_reg_index,
    input  logic [7:0] i_write_data,
    input  logic [2:0] i_event_flag,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic       o_irq_line,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    t_item   in_item, held_item;
    t_result next_result, out_result;
    logic    held_valid, out_can_load, advance;

    assign in_item.opcode     = i_opcode;
    assign in_item.reg_index  = i_reg_index;
    assign in_item.write_data = i_write_data;
    assign in_item.event_flag = i_event_flag;

    assign advance = held_valid && out_can_load;

    vtir_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    vtir_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_advance  (advance),
        .i_item     (held_item),
        .o_result   (next_result)
    );

    vtir_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (next_result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_read_data = out_result.read_data;
    assign o_irq_line  = out_result.irq_line;

endmodule

/* rtl/core/vtir_checker.sv */
// ----------------------------------------------------------------------------
// vtir_checker
// Port-level checks of the register file's pipeline behaviour.
// ----------------------------------------------------------------------------
module vtir_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_data,
    input logic       o_irq_line
);

    // No result is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid directly after reset");

    // With the output register empty the pipeline can always take a transaction.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");

    // A transaction accepted into an empty pipeline produces a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> ##1 o_out_valid)
        else $error("accepted transaction produced no result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_data) && $stable(o_irq_line)))
        else $error("stalled result changed");

endmodule

bind via_timer_interrupt_registers vtir_checker u_vtir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_read_data (o_read_data),
    .o_irq_line  (o_irq_line)
);
